// ===== rtl/core/bitmap_page_frame_allocator_assert.svh =====
// Assertion macros for the page allocator checker.
// No dependencies; included by the checker file only.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH

// property checked at every edge, reset included
`define BPFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// property checked only out of reset
`define BPFA_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== rtl/core/bpfa_pkg.sv =====
// Shared constants, codes, result struct and popcount for the page allocator.
// No dependencies.
package bpfa_pkg;
    localparam int unsigned MAX_PAGES_DEF = 32768;
    localparam logic [15:0] LOW_FLOOR_RST = 16'd256;

    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_FREE  = 3'd1;
    localparam logic [2:0] OP_RSRV  = 3'd2;
    localparam logic [2:0] OP_ADD   = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    localparam logic [1:0] STS_OK  = 2'd0;
    localparam logic [1:0] STS_OOM = 2'd1;
    localparam logic [1:0] STS_REJ = 2'd2;

    localparam logic [7:0] CFG_TOTAL = 8'd0;
    localparam logic [7:0] CFG_FLOOR = 8'd1;

    // word engine modes
    localparam logic [2:0] MD_SCAN = 3'd0;
    localparam logic [2:0] MD_SET  = 3'd1;
    localparam logic [2:0] MD_CLR  = 3'd2;
    localparam logic [2:0] MD_ADD  = 3'd3;
    localparam logic [2:0] MD_CNT  = 3'd4;

    typedef struct packed {
        logic        we;
        logic [31:0] wdata;
        logic [5:0]  cnt;
        logic        cnt_up;
        logic        hit;
        logic [4:0]  hit_bit;
    } t_word_res;

    function automatic logic [5:0] pop32(input logic [31:0] v);
        logic [5:0] s;
        s = '0;
        for (int i = 0; i < 32; i++) begin
            s = s + 6'(v[i]);
        end
        return s;
    endfunction
endpackage

// ===== rtl/core/bpfa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/bpfa_word_unit.sv =====
// Per-word modify and first-fit scan logic for one 32-page map word.
// Depends on bpfa_pkg.
module bpfa_word_unit
    import bpfa_pkg::*;
#(
    parameter int PGW = 17,
    parameter int AW  = 10
) (
    input  logic [2:0]     i_mode,
    input  logic [AW-1:0]  i_addr,
    input  logic [31:0]    i_word,
    input  logic [PGW-1:0] i_lo,
    input  logic [PGW-1:0] i_hi,
    input  logic [PGW-1:0] i_total,
    input  logic [PGW-1:0] i_len,
    input  logic [PGW-1:0] i_carry,
    output t_word_res      o_res,
    output logic [PGW-1:0] o_carry
);
    logic [31:0]    inr;
    logic [31:0]    blw;
    logic [31:0]    freeb;
    logic [PGW-1:0] run [32];

    always_comb begin
        logic [PGW-1:0] page;
        for (int i = 0; i < 32; i++) begin
            page   = (PGW'(i_addr) << 5) | PGW'(i);
            inr[i] = (page >= i_lo) && (page < i_hi);
            blw[i] = page < i_total;
        end
        freeb = ~i_word & inr;
    end

    // run of free pages ending at each bit, carried in from earlier words
    always_comb begin
        logic       allf;
        logic [4:0] lu;
        for (int i = 0; i < 32; i++) begin
            allf = 1'b1;
            lu   = '0;
            for (int j = 0; j < 32; j++) begin
                if (j <= i && !freeb[j]) begin
                    allf = 1'b0;
                    lu   = 5'(j);
                end
            end
            run[i] = allf ? i_carry + PGW'(i + 1) : PGW'(i) - PGW'(lu);
        end
    end

    always_comb begin
        o_res = '0;
        for (int i = 31; i >= 0; i--) begin
            if (run[i] >= i_len) begin
                o_res.hit     = 1'b1;
                o_res.hit_bit = 5'(i);
            end
        end
        o_res.cnt_up = 1'b1;
        o_res.wdata  = i_word;
        unique case (i_mode)
            MD_SET: begin
                o_res.we     = 1'b1;
                o_res.wdata  = i_word | inr;
                o_res.cnt    = pop32(inr & ~i_word);
                o_res.cnt_up = 1'b0;
            end
            MD_CLR: begin
                o_res.we    = 1'b1;
                o_res.wdata = i_word & ~inr;
                o_res.cnt   = pop32(inr & i_word);
            end
            MD_ADD: begin
                o_res.we    = 1'b1;
                o_res.wdata = i_word & ~inr;
                o_res.cnt   = pop32(inr & i_word & blw);
            end
            MD_CNT: begin
                o_res.cnt = pop32(~i_word & blw);
            end
            default: begin
                o_res.hit = o_res.hit;
            end
        endcase
        if (i_mode != MD_SCAN) begin
            o_res.hit = 1'b0;
        end
    end

    assign o_carry = run[31];
endmodule

// ===== rtl/core/bitmap_page_frame_allocator.sv =====
// Bitmap page allocator top level; depends on bpfa_pkg, bpfa_ram and bpfa_word_unit.
// A query or rejection goes straight to the finish; the other ops and a failed allocation
// visit each map word in range (32 pages a word) in turn; an allocation that fits scans
// up to the hit, then goes back and rewrites the words of the run.
// Throughput: one request at a time; a result held by the receiver stalls the finish.
// Reset: clearing pass writes the map to used, config taken meanwhile.
module bitmap_page_frame_allocator
    import bpfa_pkg::*;
#(
    parameter int unsigned MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_op,
    input  logic [14:0] i_page_index,
    input  logic [15:0] i_run_length,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [14:0] o_start_page,
    output logic [15:0] o_free_pages,
    output logic [15:0] o_used_pages,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int WORDS = MAX_PAGES / 32;
    localparam int AW    = $clog2(WORDS);
    // page arithmetic wide enough for page_index + run_length and for MAX_PAGES
    localparam int PGW   = ($clog2(MAX_PAGES) + 1 > 17) ? $clog2(MAX_PAGES) + 1 : 17;

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    localparam logic [PGW-1:0] MAXP = PGW'(MAX_PAGES);

    logic [2:0]     r_state, n_state;
    logic [AW-1:0]  r_clr, n_clr;
    logic [PGW-1:0] r_total, n_total;
    logic [15:0]    r_floor, n_floor;
    logic [15:0]    r_free, n_free;
    logic [2:0]     r_op, n_op;
    logic [14:0]    r_first, n_first;
    logic [15:0]    r_len, n_len;
    logic           r_recnt, n_recnt;
    logic           r_found, n_found;
    logic [PGW-1:0] r_cand, n_cand;
    logic [1:0]     r_status, n_status;
    logic [2:0]     r_mode, n_mode;
    logic [PGW-1:0] r_lo, n_lo;
    logic [PGW-1:0] r_hi, n_hi;
    logic [AW-1:0]  r_addr, n_addr;
    logic [AW-1:0]  r_last, n_last;
    logic [AW-1:0]  r_daddr, n_daddr;
    logic           r_more, n_more;
    logic           r_dv, n_dv;
    logic [PGW-1:0] r_carry, n_carry;
    logic           r_ovalid, n_ovalid;
    logic [1:0]     r_ostatus, n_ostatus;
    logic [14:0]    r_ostart, n_ostart;
    logic [15:0]    r_ofree, n_ofree;
    logic [15:0]    r_oused, n_oused;

    logic           in_xfer, cfg_xfer, issue;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [31:0]    ram_wdata, ram_rdata;
    t_word_res      wres;
    logic [PGW-1:0] wcarry;
    logic [PGW-1:0] w_first, w_len, w_end, w_hi_tot, w_lo_add, w_hi_add;
    logic [PGW-1:0] sat_total;

    // last word touched by a range that ends just below hi
    function automatic logic [AW-1:0] hi_m1(input logic [PGW-1:0] h);
        logic [PGW-1:0] t;
        t = h - PGW'(1);
        return t[AW+4:5];
    endfunction

    assign o_ready     = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_CLR) || (r_state == S_IDLE);
    assign in_xfer     = i_valid && o_ready;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    assign w_first   = PGW'(r_first);
    assign w_len     = PGW'(r_len);
    assign w_end     = w_first + w_len;
    assign w_hi_tot  = (w_end < r_total) ? w_end : r_total;
    assign w_lo_add  = (w_first > PGW'(r_floor)) ? w_first : PGW'(r_floor);
    assign w_hi_add  = (w_end < MAXP) ? w_end : MAXP;
    assign sat_total = (32'(i_cfg_data) > 32'(MAX_PAGES)) ? MAXP : PGW'(i_cfg_data);

    // reads run ahead of processing by one word; each pass visits a word once
    assign issue = (r_state == S_RUN) && r_more && !(r_dv && wres.hit);

    bpfa_ram #(
        .WIDTH (32),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    bpfa_word_unit #(
        .PGW (PGW),
        .AW  (AW)
    ) u_word (
        .i_mode  (r_mode),
        .i_addr  (r_daddr),
        .i_word  (ram_rdata),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .i_total (r_total),
        .i_len   (w_len),
        .i_carry (r_carry),
        .o_res   (wres),
        .o_carry (wcarry)
    );

    // clear pass writes all-used; otherwise write back the processed word
    always_comb begin
        if (r_state == S_CLR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '1;
        end else begin
            ram_we    = (r_state == S_RUN) && r_dv && wres.we;
            ram_waddr = r_daddr;
            ram_wdata = wres.wdata;
        end
    end

    always_comb begin
        logic           skip;
        logic [PGW-1:0] lo, hi;
        logic [2:0]     md;
        n_state   = r_state;
        n_clr     = r_clr;
        n_total   = r_total;
        n_floor   = r_floor;
        n_free    = r_free;
        n_op      = r_op;
        n_first   = r_first;
        n_len     = r_len;
        n_recnt   = r_recnt;
        n_found   = r_found;
        n_cand    = r_cand;
        n_status  = r_status;
        n_mode    = r_mode;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_addr    = r_addr;
        n_last    = r_last;
        n_daddr   = r_daddr;
        n_more    = r_more;
        n_dv      = issue;
        n_carry   = r_carry;
        n_ovalid  = r_ovalid;
        n_ostatus = r_ostatus;
        n_ostart  = r_ostart;
        n_ofree   = r_ofree;
        n_oused   = r_oused;
        skip      = 1'b0;
        lo        = '0;
        hi        = '0;
        md        = MD_CNT;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        if (cfg_xfer) begin
            if (i_cfg_index == CFG_TOTAL) begin
                n_total = sat_total;
                // map is all used during the clear pass, so the count stays zero
                if (r_state == S_IDLE) begin
                    n_free  = '0;
                    n_recnt = 1'b1;
                    n_state = S_START;
                end
            end else if (i_cfg_index == CFG_FLOOR) begin
                n_floor = i_cfg_data;
            end
        end

        unique case (r_state)
            S_CLR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_op     = i_op;
                    n_first  = i_page_index;
                    n_len    = i_run_length;
                    n_found  = 1'b0;
                    n_status = STS_OK;
                    n_state  = S_START;
                end
            end
            S_START: begin
                if (r_recnt) begin
                    lo = '0;
                    hi = r_total;
                    md = MD_CNT;
                end else begin
                    unique case (r_op)
                        OP_ALLOC: begin
                            if (r_len == '0) begin
                                skip     = 1'b1;
                                n_status = STS_REJ;
                            end else if (r_found) begin
                                lo = r_cand;
                                hi = r_cand + w_len;
                                md = MD_SET;
                            end else begin
                                lo = '0;
                                hi = r_total;
                                md = MD_SCAN;
                            end
                        end
                        OP_FREE: begin
                            if (r_len == '0 || r_first == '0) begin
                                skip     = 1'b1;
                                n_status = STS_REJ;
                            end else begin
                                lo = w_first;
                                hi = w_hi_tot;
                                md = MD_CLR;
                            end
                        end
                        OP_RSRV: begin
                            lo = w_first;
                            hi = w_hi_tot;
                            md = MD_SET;
                        end
                        OP_ADD: begin
                            lo = w_lo_add;
                            hi = w_hi_add;
                            md = MD_ADD;
                        end
                        default: begin
                            skip = 1'b1;
                        end
                    endcase
                end
                n_mode  = md;
                n_lo    = lo;
                n_hi    = hi;
                n_carry = '0;
                if (skip || lo >= hi) begin
                    // an empty scan range means no run can exist
                    if (!skip && md == MD_SCAN) begin
                        n_status = STS_OOM;
                    end
                    n_state = S_FIN;
                end else begin
                    n_addr  = lo[AW+4:5];
                    n_last  = hi_m1(hi);
                    n_more  = 1'b1;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (issue) begin
                    n_daddr = r_addr;
                    if (r_addr == r_last) begin
                        n_more = 1'b0;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
                if (r_dv) begin
                    n_free  = wres.cnt_up ? r_free + 16'(wres.cnt) : r_free - 16'(wres.cnt);
                    n_carry = wcarry;
                    if (wres.hit) begin
                        // first fit found: go back and mark the run used
                        n_found = 1'b1;
                        n_cand  = ((PGW'(r_daddr) << 5) | PGW'(wres.hit_bit))
                                  + PGW'(1) - w_len;
                        n_more  = 1'b0;
                        n_state = S_START;
                    end else if (r_daddr == r_last) begin
                        if (r_mode == MD_SCAN) begin
                            n_status = STS_OOM;
                        end
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (r_recnt) begin
                    n_recnt = 1'b0;
                    n_state = S_IDLE;
                end else if (!r_ovalid || i_ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_ostart  = (r_op == OP_ALLOC && r_found) ? r_cand[14:0] : '0;
                    n_ofree   = r_free;
                    n_oused   = 16'(r_total) - r_free;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_total  <= '0;
            r_floor  <= LOW_FLOOR_RST;
            r_free   <= '0;
            r_recnt  <= 1'b0;
            r_more   <= 1'b0;
            r_dv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_total  <= n_total;
            r_floor  <= n_floor;
            r_free   <= n_free;
            r_recnt  <= n_recnt;
            r_more   <= n_more;
            r_dv     <= n_dv;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_first   <= n_first;
        r_len     <= n_len;
        r_found   <= n_found;
        r_cand    <= n_cand;
        r_status  <= n_status;
        r_mode    <= n_mode;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_addr    <= n_addr;
        r_last    <= n_last;
        r_daddr   <= n_daddr;
        r_carry   <= n_carry;
        r_ostatus <= n_ostatus;
        r_ostart  <= n_ostart;
        r_ofree   <= n_ofree;
        r_oused   <= n_oused;
    end

    assign o_valid      = r_ovalid;
    assign o_status     = r_ostatus;
    assign o_start_page = r_ostart;
    assign o_free_pages = r_ofree;
    assign o_used_pages = r_oused;
endmodule

// ===== rtl/core/bpfa_checker.sv =====
// Port-level checker for the page allocator, bound to the top level.
// Depends on bpfa_pkg and bitmap_page_frame_allocator_assert.svh.
`include "bitmap_page_frame_allocator_assert.svh"
module bpfa_checker
    import bpfa_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [14:0] o_start_page
);
    `BPFA_ASSERT_ALWAYS(a_clear_after_reset, i_clk, !i_rst_n |=> !o_ready, "ready after reset")
    `BPFA_ASSERT_RUN(a_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid, "result dropped")
    `BPFA_ASSERT_RUN(a_status, i_clk, i_rst_n, o_valid |-> o_status != 2'd3, "bad status")
    `BPFA_ASSERT_RUN(a_start, i_clk, i_rst_n, o_valid && o_status != STS_OK |-> o_start_page == '0, "start on fail")
endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_status     (o_status),
    .o_start_page (o_start_page)
);

// ===== dv/tb_top.sv =====
// Self-checking bench for the bitmap page frame allocator: directed plus random requests.
// Predicts each result from a local copy of the used-page map; depends on bpfa_pkg.
module tb_top
    import bpfa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPAGES      = 32768;
    localparam int IDLE_LIMIT  = 400000;   // map clear plus a full-map allocate scan, with margin

    typedef struct packed {
        logic [2:0]  op;
        logic [14:0] page;
        logic [15:0] len;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] start;
        logic [15:0] free_n;
        logic [15:0] used_n;
    } rsp_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_op = '0;
    logic [14:0] i_page_index = '0;
    logic [15:0] i_run_length = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [14:0] o_start_page;
    logic [15:0] o_free_pages;
    logic [15:0] o_used_pages;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    bitmap_page_frame_allocator dut (.*);

    always #2 i_clk = ~i_clk;

    // predictor state
    bit          used_map [NPAGES];
    int unsigned free_cnt;
    int unsigned tot_pages;
    int unsigned floor_pages;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   mismatches = 0;
    int   idle_cycles = 0;
    bit   stim_done = 0;

    function automatic void apply_total(input logic [15:0] v);
        tot_pages = (v > NPAGES) ? NPAGES : v;
        free_cnt = 0;
        for (int p = 0; p < tot_pages; p++) if (!used_map[p]) free_cnt++;
    endfunction

    function automatic void set_page(input int unsigned p);
        if (p < tot_pages && !used_map[p]) begin
            used_map[p] = 1; free_cnt--;
        end
    endfunction

    function automatic void clear_page(input int unsigned p);
        if (p < tot_pages && used_map[p]) begin
            used_map[p] = 0; free_cnt++;
        end
    endfunction

    function automatic rsp_t predict_alloc(input req_t r);
        rsp_t        o;
        int unsigned lim, run, cand;
        bit          found;
        o = '0;
        lim = r.page + r.len;
        run = 0; cand = 0; found = 0;
        case (r.op)
            OP_ALLOC: begin
                if (r.len == 0) o.status = STS_REJ;
                else begin
                    for (int unsigned p = 0; p < tot_pages && !found; p++) begin
                        if (!used_map[p]) begin
                            if (run == 0) cand = p;
                            run++;
                            if (run == r.len) found = 1;
                        end else run = 0;
                    end
                    if (found) begin
                        for (int unsigned p = cand; p < cand + r.len; p++) set_page(p);
                        o.start = cand[14:0];
                    end else o.status = STS_OOM;
                end
            end
            OP_FREE: begin
                if (r.len == 0 || r.page == 0) o.status = STS_REJ;
                else for (int unsigned p = r.page; p < lim && p < tot_pages; p++) clear_page(p);
            end
            OP_RSRV: for (int unsigned p = r.page; p < lim && p < tot_pages; p++) set_page(p);
            OP_ADD: begin
                // pages above total are released too, but stay uncounted
                for (int unsigned p = r.page; p < lim && p < NPAGES; p++) begin
                    if (p >= floor_pages && used_map[p]) begin
                        used_map[p] = 0;
                        if (p < tot_pages) free_cnt++;
                    end
                end
            end
            default: ;
        endcase
        o.free_n = free_cnt[15:0];
        o.used_n = 16'(tot_pages - free_cnt);
        return o;
    endfunction

    // driver: bursts of transfers with random gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    req_t r;
                    r = pending_reqs.pop_front();
                    expected_rsps.push_back(predict_alloc(r));
                    i_op <= r.op; i_page_index <= r.page; i_run_length <= r.len;
                    i_valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else burst_left <= burst_left - 1;
                end else i_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern: rotating 8-bit mask, reseeded now and then
    logic [7:0] stall_pat = 8'hFF;
    always @(posedge i_clk) begin
        stall_pat <= ($urandom_range(0, 63) == 0) ? 8'($urandom) | 8'h11
                                                  : {stall_pat[6:0], stall_pat[7]};
        i_ready <= stall_pat[0];
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            rsp_t got, exp_r;
            got = {o_status, o_start_page, o_free_pages, o_used_pages};
            if (expected_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                exp_r = expected_rsps.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp st=%0d sp=%0d fr=%0d us=%0d ",
                                  "got st=%0d sp=%0d fr=%0d us=%0d"},
                                 exp_r.status, exp_r.start, exp_r.free_n, exp_r.used_n,
                                 got.status, got.start, got.free_n, got.used_n);
                end
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready) ||
            (stim_done && expected_rsps.size() == 0))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_TOTAL) apply_total(val);
        else if (idx == CFG_FLOOR) floor_pages = val;
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic void push(input logic [2:0] op, input int pg, input int ln);
        req_t r;
        r.op = op; r.page = pg[14:0]; r.len = ln[15:0];
        pending_reqs.push_back(r);
    endfunction

    // mostly small runs in a window near the managed range
    function automatic void push_random();
        int unsigned k, pg, ln;
        k = $urandom_range(0, 19);
        pg = (k == 0) ? $urandom_range(0, 32767) : $urandom_range(0, tot_pages + 40) & 16'h7FFF;
        ln = (k == 1) ? $urandom_range(0, 65535) : $urandom_range(0, 70);
        push($urandom_range(0, 9) == 0 ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3)),
             pg, ln);
    endfunction

    initial begin
        foreach (used_map[i]) used_map[i] = 1;
        free_cnt = 0; tot_pages = 0; floor_pages = 256;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty allocator, then a small managed range
        push(OP_ALLOC, 0, 1);
        push(OP_ADD, 0, 300);
        push(OP_QUERY, 0, 0);
        drain();
        write_reg(CFG_FLOOR, 16);
        write_reg(CFG_TOTAL, 200);
        push(OP_ADD, 0, 0);
        push(OP_ADD, 8, 100);
        push(OP_ALLOC, 0, 0);
        push(OP_ALLOC, 0, 5);
        push(OP_ALLOC, 0, 1000);
        push(OP_FREE, 0, 4);
        push(OP_FREE, 20, 0);
        push(OP_FREE, 18, 3);
        push(OP_RSRV, 30, 10);
        push(OP_RSRV, 190, 50);
        push(OP_FREE, 150, 100);
        push(OP_ADD, 32767, 65535);
        push(OP_ALLOC, 0, 65535);
        push(3'd7, 32767, 65535);
        push(3'd5, 21845, 43690);
        push(3'd6, 10922, 21845);
        push(OP_ALLOC, 0, 200);
        drain();
        write_reg(CFG_TOTAL, 16'hFFFF);   // saturates, recount covers pages freed above old total
        write_reg(CFG_FLOOR, 0);
        push(OP_ADD, 0, 65535);
        push(OP_ALLOC, 0, 32768);
        push(OP_FREE, 1, 65535);
        push(OP_RSRV, 0, 65535);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_TOTAL, 0); write_reg(CFG_FLOOR, 0); end
                1: begin write_reg(CFG_TOTAL, 96); write_reg(CFG_FLOOR, 16'hFFFF); end
                2: begin write_reg(CFG_TOTAL, 300); write_reg(CFG_FLOOR, 256); end
                3: begin write_reg(CFG_TOTAL, 700); write_reg(CFG_FLOOR, 40); end
                4: begin write_reg(CFG_TOTAL, 32768); write_reg(CFG_FLOOR, 0);
                         write_reg(8'd9, 16'h1234); end
                default: begin write_reg(CFG_TOTAL, 1000); write_reg(CFG_FLOOR, 1); end
            endcase
            for (int n = 0; n < 85; n++) push_random();
            drain();
        end
        stim_done = 1;
        if (mismatches == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
